@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sampler position block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the condition
`define SLPA_ASSERT_NOW(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Consequent must hold in the cycle after the condition
`define SLPA_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

@@ rtl/slpa_pkg.sv @@
// Package for the sampler loop position block: default widths, register
// indexes, loop modes and sequencer states. No dependencies.
package slpa_pkg;

	localparam int FRAME_BITS_DEF    = 24;
	localparam int FRACTION_BITS_DEF = 16;
	// integer bits of the signed rate
	localparam int RATE_INT_BITS     = 8;
	localparam int CFG_INDEX_BITS    = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SAMPLE_LENGTH = 3'd0,
		REG_LOOP_FIRST    = 3'd1,
		REG_LOOP_LIMIT    = 3'd2,
		REG_LOOP_ENABLE   = 3'd3,
		REG_LOOP_MODE     = 3'd4,
		REG_SEAM_SKIP     = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_FREE,
		MODE_FWD,
		MODE_PING
	} loop_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_TEST,
		ST_DIV,
		ST_REFL,
		ST_JOIN,
		ST_DONE
	} state_t;

endpackage

@@ rtl/slpa_if.sv @@
// Valid/ready channel interfaces for the sampler loop position block.
// Depends on slpa_pkg for default widths.
interface slpa_in_if #(
	parameter int FRACTION_BITS = slpa_pkg::FRACTION_BITS_DEF
);
	import slpa_pkg::*;

	logic                                     valid;
	logic                                     ready;
	logic signed [RATE_INT_BITS+FRACTION_BITS-1:0] rate;
	logic                                     gate_on;

	modport source (output valid, output rate, output gate_on, input ready);
	modport sink   (input valid, input rate, input gate_on, output ready);
endinterface

interface slpa_out_if #(
	parameter int FRAME_BITS    = slpa_pkg::FRAME_BITS_DEF,
	parameter int FRACTION_BITS = slpa_pkg::FRACTION_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [FRAME_BITS-1:0]    frame_index;
	logic [FRACTION_BITS-1:0] frame_fraction;
	logic                     moving_backward;
	logic                     still_playing;

	modport source (output valid, output frame_index, output frame_fraction,
		output moving_backward, output still_playing, input ready);
	modport sink   (input valid, input frame_index, input frame_fraction,
		input moving_backward, input still_playing, output ready);
endinterface

@@ rtl/sample_loop_position_advance.sv @@
// Each item passes ST_ADD and ST_TEST, then ST_DONE; a ping-pong reflection goes
// through ST_REFL and a forward wrap through ST_DIV and ST_JOIN before ST_DONE. A
// new item is taken only once the last result has gone to the output register.
// The forward wrap runs a restoring remainder over the frame bits, one bit a cycle,
// on the shared adder. Reset (arst_n low, asynchronous) clears position, direction,
// registers and handshake state and sets the playing flag; then ready for an item.
`include "assert_macros.svh"

module sample_loop_position_advance #(
	parameter int FRAME_BITS    = slpa_pkg::FRAME_BITS_DEF,
	parameter int FRACTION_BITS = slpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [FRAME_BITS:0]                 cfg_data,
	slpa_in_if.sink                             in_ch,
	slpa_out_if.source                          out_ch
);
	import slpa_pkg::*;

	localparam int POS_BITS  = FRAME_BITS + FRACTION_BITS;
	localparam int ACC_BITS  = POS_BITS + 3;
	localparam int RATE_BITS = RATE_INT_BITS + FRACTION_BITS;
	localparam int REM_BITS  = FRAME_BITS + 2;
	localparam int CNT_BITS  = $clog2(FRAME_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAME_BITS - 1);
	localparam logic [ACC_BITS-1:0] POS_MAX  = {3'b000, {POS_BITS{1'b1}}};
	localparam logic [FRACTION_BITS-1:0] FRAC_ZERO = '0;

	// configuration registers
	logic [FRAME_BITS:0]   len_q;
	logic [FRAME_BITS-1:0] lstart_q;
	logic [FRAME_BITS:0]   lend_q;
	logic                  len_en_q;
	logic                  lmode_q;
	logic [FRAME_BITS-1:0] seam_q;

	// sequencer and working registers
	state_t                 state_q, state_d;
	loop_mode_t             mode_q;
	logic [RATE_BITS-1:0]   rate_q;
	logic [FRAME_BITS:0]    span_q;
	logic [FRAME_BITS:0]    dsr_q;
	logic [FRAME_BITS:0]    base_q;
	logic [ACC_BITS-1:0]    acc_q;
	logic [FRAME_BITS-1:0]  dvd_q;
	logic [FRAME_BITS:0]    rem_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [CNT_BITS-1:0]    cnt_q;

	// voice state
	logic [FRAME_BITS-1:0]    pframe_q;
	logic [FRACTION_BITS-1:0] pfrac_q;
	logic                     dir_q;
	logic                     play_q;

	// output register
	logic                     ovalid_q;
	logic [FRAME_BITS-1:0]    oframe_q;
	logic [FRACTION_BITS-1:0] ofrac_q;
	logic                     obwd_q;
	logic                     oplay_q;

	// shared adder
	logic [ACC_BITS-1:0] op_a, op_b, sum, sum_clamped;
	logic                op_sub;

	logic                accept, out_load, loop_ok, seam_big, ping_hit;
	logic [REM_BITS-1:0] rem_sh;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_load = (state_q == ST_DONE) && (!ovalid_q || out_ch.ready);
	assign rem_sh   = {rem_q, dvd_q[FRAME_BITS-1]};
	assign seam_big = ({1'b0, seam_q} >= span_q);

	// loop region is usable only with a held gate and sane bounds
	assign loop_ok = len_en_q && in_ch.gate_on && ({1'b0, lstart_q} < lend_q)
		&& (lend_q <= len_q);

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			lstart_q <= '0;
			lend_q   <= '0;
			len_en_q <= 1'b0;
			lmode_q  <= 1'b0;
			seam_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_LENGTH: len_q    <= cfg_data;
				REG_LOOP_FIRST:    lstart_q <= cfg_data[FRAME_BITS-1:0];
				REG_LOOP_LIMIT:    lend_q   <= cfg_data;
				REG_LOOP_ENABLE:   len_en_q <= cfg_data[0];
				REG_LOOP_MODE:     lmode_q  <= cfg_data[0];
				REG_SEAM_SKIP:     seam_q   <= cfg_data[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// operand selection for the shared adder/subtractor
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_ADD: begin
				op_a   = {3'b000, pframe_q, pfrac_q};
				op_b   = {{(ACC_BITS-RATE_BITS){rate_q[RATE_BITS-1]}}, rate_q};
				op_sub = (mode_q == MODE_PING) && dir_q;
			end
			ST_TEST: begin
				op_a   = acc_q;
				op_b   = ((mode_q == MODE_PING) && dir_q)
					? {3'b000, lstart_q, FRAC_ZERO} : {2'b00, lend_q, FRAC_ZERO};
				op_sub = 1'b1;
			end
			ST_DIV: begin
				op_a   = {{(ACC_BITS-REM_BITS){1'b0}}, rem_sh};
				op_b   = {{(ACC_BITS-FRAME_BITS-1){1'b0}}, dsr_q};
				op_sub = 1'b1;
			end
			ST_REFL: begin
				// twice the bound the position went past
				op_a   = dir_q ? {2'b00, lstart_q, FRAC_ZERO, 1'b0}
					: {1'b0, lend_q, FRAC_ZERO, 1'b0};
				op_b   = acc_q;
				op_sub = 1'b1;
			end
			ST_JOIN: begin
				op_a = {2'b00, base_q, FRAC_ZERO};
				op_b = {2'b00, rem_q, frac_q};
			end
			default: ;
		endcase
	end

	assign sum = op_a + (op_sub ? ~op_b : op_b) + ACC_BITS'(op_sub);

	// saturate to the position range
	always_comb begin
		if (sum[ACC_BITS-1])
			sum_clamped = '0;
		else if (sum[ACC_BITS-2:POS_BITS] != '0)
			sum_clamped = POS_MAX;
		else
			sum_clamped = sum;
	end

	// ping-pong bound crossed: at or past the end going forward, at or below start reversed
	assign ping_hit = dir_q ? (sum[ACC_BITS-1] || (sum == '0)) : !sum[ACC_BITS-1];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_ADD;
			end
			ST_ADD: state_d = ST_TEST;
			ST_TEST: begin
				case (mode_q)
					MODE_FWD:  state_d = !sum[ACC_BITS-1] ? ST_DIV : ST_DONE;
					MODE_PING: state_d = ping_hit ? ST_REFL : ST_DONE;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST)
					state_d = ST_JOIN;
			end
			ST_REFL: state_d = ST_DONE;
			ST_JOIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// working registers, stepped by the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FREE;
			cnt_q  <= '0;
			dir_q  <= 1'b0;
			play_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rate_q <= in_ch.rate;
						span_q <= lend_q - {1'b0, lstart_q};
						if (!loop_ok)
							mode_q <= MODE_FREE;
						else if (lmode_q)
							mode_q <= MODE_PING;
						else
							mode_q <= MODE_FWD;
					end
				end
				ST_ADD: begin
					acc_q <= sum_clamped;
					// wrap divisor and landing frame; an oversized seam counts as none
					dsr_q  <= seam_big ? span_q : span_q - {1'b0, seam_q};
					base_q <= {1'b0, lstart_q} + (seam_big ? '0 : {1'b0, seam_q});
				end
				ST_TEST: begin
					play_q <= (mode_q != MODE_FREE)
						|| ({1'b0, acc_q[POS_BITS-1:FRACTION_BITS]} < len_q);
					dvd_q  <= sum[POS_BITS-1:FRACTION_BITS];
					frac_q <= sum[FRACTION_BITS-1:0];
					rem_q  <= '0;
					cnt_q  <= '0;
				end
				ST_DIV: begin
					// restoring step: keep the difference when it does not go negative
					rem_q <= !sum[ACC_BITS-1] ? sum[FRAME_BITS:0] : rem_sh[FRAME_BITS:0];
					dvd_q <= {dvd_q[FRAME_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
				ST_REFL: begin
					acc_q <= sum_clamped;
					dir_q <= !dir_q;
				end
				ST_JOIN: acc_q <= sum_clamped;
				default: ;
			endcase
		end
	end

	// voice position, updated as the result is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pframe_q <= '0;
			pfrac_q  <= '0;
		end else if (out_load) begin
			pframe_q <= acc_q[POS_BITS-1:FRACTION_BITS];
			pfrac_q  <= acc_q[FRACTION_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oframe_q <= acc_q[POS_BITS-1:FRACTION_BITS];
			ofrac_q  <= acc_q[FRACTION_BITS-1:0];
			obwd_q   <= dir_q;
			oplay_q  <= play_q;
		end
	end

	assign in_ch.ready            = (state_q == ST_IDLE);
	assign out_ch.valid           = ovalid_q;
	assign out_ch.frame_index     = oframe_q;
	assign out_ch.frame_fraction  = ofrac_q;
	assign out_ch.moving_backward = obwd_q;
	assign out_ch.still_playing   = oplay_q;

	// checks
	`SLPA_ASSERT_NOW(a_rem_below_dsr, state_q == ST_DIV, rem_q < dsr_q,
		"remainder not below divisor during division")
	`SLPA_ASSERT_NOW(a_acc_in_range, state_q == ST_TEST, acc_q[ACC_BITS-1:POS_BITS] == '0,
		"sum after add left the position range")
	`SLPA_ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && (cnt_q == CNT_LAST),
		state_q == ST_JOIN, "division did not end after the last frame bit")
	`SLPA_ASSERT_NOW(a_dir_flip, dir_q != $past(dir_q),
		($past(state_q) == ST_REFL) && ($past(mode_q) == MODE_PING),
		"direction changed outside a ping-pong reflection")

endmodule
